[rtl/core/temp_scratchpad_crc_decoder_unit_assert.svh]
// Assertion macros shared by the decoder RTL.
`ifndef TEMP_SCRATCHPAD_CRC_DECODER_UNIT_ASSERT_SVH
`define TEMP_SCRATCHPAD_CRC_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSCD_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSCD_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tscd_pkg.sv]
package tscd_pkg;

  localparam logic [7:0] FAMILY_HALF_DEG = 8'h10;
  localparam logic [7:0] CRC_POLY_REFL   = 8'h8C;

  localparam logic [3:0] POS_FIRST = 4'd0;
  localparam logic [3:0] POS_LSB   = 4'd0;
  localparam logic [3:0] POS_MSB   = 4'd1;
  localparam logic [3:0] POS_CFG   = 4'd4;
  localparam logic [3:0] POS_REM   = 4'd6;
  localparam logic [3:0] POS_PER_C = 4'd7;
  localparam logic [3:0] POS_CRC   = 4'd8;
  localparam logic [3:0] POS_IDLE  = 4'd9;

  localparam logic [7:0]  COUNT_PER_C_FULL = 8'h10;
  localparam logic [15:0] REFINE_MASK      = 16'hFFF0;
  localparam logic [15:0] REFINE_BIAS      = 16'd12;

  localparam logic [7:0] RES_FIELD_MASK = 8'h60;
  localparam logic [7:0] RES_9BIT       = 8'h00;
  localparam logic [7:0] RES_10BIT      = 8'h20;
  localparam logic [7:0] RES_11BIT      = 8'h40;

  localparam logic [15:0] MASK_9BIT  = 16'hFFF8;
  localparam logic [15:0] MASK_10BIT = 16'hFFFC;
  localparam logic [15:0] MASK_11BIT = 16'hFFFE;

  // Scratchpad bytes that the decode needs.
  typedef struct packed {
    logic [7:0] lsb;
    logic [7:0] msb;
    logic [7:0] cfg;
    logic [7:0] cnt_remain;
    logic [7:0] cnt_per_c;
  } tscd_kept_t;

  // What the frame tracker says about the word now at its input.
  typedef struct packed {
    logic fire;
    logic crc_bad;
  } tscd_frame_res_t;

  // Reflected CRC-8 over one byte, bit by bit.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] crc;
    logic       mix;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ b[i];
      crc = {1'b0, crc[7:1]};
      if (mix) begin
        crc = crc ^ CRC_POLY_REFL;
      end
    end
    return crc;
  endfunction

endpackage

[rtl/core/temp_scratchpad_crc_decoder_unit.sv]
// Channel   Ports                                              Direction
// input     in_valid in_stall in_data_byte in_family_code      in
//           in_frame_start
// result    out_valid out_stall out_temperature out_crc_bad    out
//
// One word per cycle is taken unless the input stalls; each word is held in the
// input register, and its result, if any, is loaded into the output register as
// the word leaves it. Only the CRC byte of a frame yields a result.
// Synchronous active-low reset clears position, CRC and valid flags.
// A stalled result holds the input register, and the input stalls only when
// both the input register and the output register are full.
`include "temp_scratchpad_crc_decoder_unit_assert.svh"

module temp_scratchpad_crc_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic [7:0]         in_family_code,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_temperature,
  output logic               out_crc_bad
);
  import tscd_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [7:0]  s1_data_r;
  logic [7:0]  s1_family_r;
  logic        s1_start_r;
  logic        s1_go;
  logic        in_take;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [15:0] out_temp_r;
  logic        out_crc_bad_r;
  logic        out_load;

  tscd_frame_res_t frame_res;
  tscd_kept_t      kept;
  logic [15:0]     dec_temp;

  // The first stage moves on whenever the output register can take a word.
  assign s1_go    = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign out_load = s1_go && frame_res.fire;

  assign s1_valid_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : ((out_valid_r && out_stall) ? 1'b1 : 1'b0);

  tscd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_go     (s1_go),
    .data_byte   (s1_data_r),
    .frame_start (s1_start_r),
    .res         (frame_res),
    .kept        (kept)
  );

  tscd_temp u_temp (
    .kept        (kept),
    .family_code (s1_family_r),
    .temperature (dec_temp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r   <= in_data_byte;
      s1_family_r <= in_family_code;
      s1_start_r  <= in_frame_start;
    end
    if (out_load) begin
      out_crc_bad_r <= frame_res.crc_bad;
      out_temp_r    <= frame_res.crc_bad ? 16'h0000 : dec_temp;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = $signed(out_temp_r);
  assign out_crc_bad     = out_crc_bad_r;

  `TSCD_ASSERT_SAME(a_bad_is_zero, clk, rst_n, out_valid_r && out_crc_bad_r,
                    out_temp_r == 16'h0000, "CRC error word carries a nonzero temperature")
  `TSCD_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall,
                    s1_valid_r && out_valid_r && out_stall, "input stalled without a full pipe")
  `TSCD_ASSERT_NEXT(a_result_lands, clk, rst_n, out_load,
                    out_valid_r, "decoded result did not reach the output register")

endmodule

[rtl/core/tscd_frame.sv]
module tscd_frame (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_go,
  input  logic [7:0]                data_byte,
  input  logic                      frame_start,
  output tscd_pkg::tscd_frame_res_t res,
  output tscd_pkg::tscd_kept_t      kept
);
  import tscd_pkg::*;

  logic [3:0] pos_r;
  logic [3:0] pos_nxt;
  logic [7:0] crc_r;
  logic [7:0] crc_nxt;
  logic [3:0] pos_eff;
  logic [7:0] crc_eff;
  tscd_kept_t kept_r;

  // A frame start overrides whatever position and CRC were left behind.
  assign pos_eff = frame_start ? POS_FIRST : pos_r;
  assign crc_eff = frame_start ? 8'h00 : crc_r;

  assign res.fire    = (pos_eff == POS_CRC);
  assign res.crc_bad = (data_byte != crc_eff);
  assign kept        = kept_r;

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (item_go) begin
      if (pos_eff < POS_CRC) begin
        crc_nxt = crc8_update(crc_eff, data_byte);
        pos_nxt = pos_eff + 4'd1;
      end else begin
        crc_nxt = crc_eff;
        pos_nxt = POS_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_FIRST;
      crc_r <= 8'h00;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go) begin
      case (pos_eff)
        POS_LSB:   kept_r.lsb        <= data_byte;
        POS_MSB:   kept_r.msb        <= data_byte;
        POS_CFG:   kept_r.cfg        <= data_byte;
        POS_REM:   kept_r.cnt_remain <= data_byte;
        POS_PER_C: kept_r.cnt_per_c  <= data_byte;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/tscd_temp.sv]
module tscd_temp (
  input  tscd_pkg::tscd_kept_t kept,
  input  logic [7:0]           family_code,
  output logic [15:0]          temperature
);
  import tscd_pkg::*;

  logic [15:0] raw;
  logic [15:0] raw_x8;
  logic [15:0] refined;
  logic [7:0]  res_field;

  assign raw       = {kept.msb, kept.lsb};
  assign raw_x8    = {raw[12:0], 3'b000};
  // Half-degree reading refined by the remaining count, wrapping at 16 bits.
  assign refined   = (raw_x8 & REFINE_MASK) + REFINE_BIAS - {8'h00, kept.cnt_remain};
  assign res_field = kept.cfg & RES_FIELD_MASK;

  always_comb begin
    temperature = raw;
    if (family_code == FAMILY_HALF_DEG) begin
      temperature = (kept.cnt_per_c == COUNT_PER_C_FULL) ? refined : raw_x8;
    end else begin
      case (res_field)
        RES_9BIT:  temperature = raw & MASK_9BIT;
        RES_10BIT: temperature = raw & MASK_10BIT;
        RES_11BIT: temperature = raw & MASK_11BIT;
        default:   temperature = raw;
      endcase
    end
  end

endmodule
